### rtl/rot_pkg.sv
// Package for the rectangle obstacle table: codes, constants, result type.
// No dependencies.
`default_nettype none
package rot_pkg;
    localparam int MAX_RECTS_DEF  = 16;
    localparam int COORD_BITS_DEF = 16;
    localparam logic [15:0] MIN_SIDE_RESET = 16'd10;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_SELECT = 2'd2;
    localparam logic [1:0] CMD_CHECK  = 2'd3;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_OPPOSITE = 3'd1;
    localparam logic [2:0] ST_SMALL    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NONE     = 3'd4;

    // per-cell test outcome passed from cell to top
    typedef struct packed {
        logic contains;
        logic hit;
    } cell_flags_t;
endpackage
`default_nettype wire

### rtl/rect_obstacle_table_hit_test.sv
// Top level of the rectangle obstacle table: command decode, chain of cells,
// priority pick and output register. Uses rot_pkg and rot_cell.
//
// channel  | dir | fields (low bit up)
// s_axis   | in  | tdata: cmd[1:0] ax ay bx by (66 bits, padded to 72)
// m_axis   | out | tdata: status[2:0] hit hit_index[3:0] sel_valid sel_index[3:0]
//          |     |        entry_count[4:0] (18 bits, padded to 24)
// cfg      | in  | data: min_side[15:0]
//
// One command per cycle unless stalled: every cell tests its rectangle at
// once and a priority pick over the cells chooses the index; the output
// register is the only stage. A beat is taken whenever the output register
// is empty or drained in the same cycle. Reset empties table and selection.
`default_nettype none
module rect_obstacle_table_hit_test import rot_pkg::*; #(
    parameter int MAX_RECTS  = MAX_RECTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd, ax, ay, bx, by
    input  wire [((4*COORD_BITS+9)/8)*8-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // status, hit, hit_index, sel_valid, sel_index, entry_count
    output logic [((2*((MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1) +
                    $clog2(MAX_RECTS + 1) + 12)/8)*8-1:0] m_axis_tdata,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [15:0]  cfg_data        // min_side
);
    localparam int CB = COORD_BITS;
    localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int NW = $clog2(MAX_RECTS + 1);
    localparam int ODW = $bits(m_axis_tdata);

    logic [1:0] cmd;
    logic signed [CB-1:0] ax, ay, bx, by;
    assign cmd = s_axis_tdata[1:0];
    assign ax  = s_axis_tdata[2+CB-1:2];
    assign ay  = s_axis_tdata[2+2*CB-1:2+CB];
    assign bx  = s_axis_tdata[2+3*CB-1:2+2*CB];
    assign by  = s_axis_tdata[2+4*CB-1:2+3*CB];

    logic [15:0]    min_side_reg;
    logic [NW-1:0]  count_reg, count_next;
    logic           sel_valid_reg, sel_valid_next;
    logic [IW-1:0]  sel_index_reg, sel_index_next;
    logic           out_valid_reg;
    logic [ODW-1:0] out_data_reg, out_data_next;

    logic accept;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

    // add and delete decode
    logic oppx, oppy, too_small, full, do_add, do_del;
    logic [CB:0] w, h;
    logic [CB-1:0] nl, nb;
    always_comb
    begin
        oppx = (ax[CB-1] && bx > 0) || (ax > 0 && bx[CB-1]);
        oppy = (ay[CB-1] && by > 0) || (ay > 0 && by[CB-1]);
        w  = (ax > bx) ? (CB+1)'(ax) - (CB+1)'(bx) : (CB+1)'(bx) - (CB+1)'(ax);
        h  = (ay > by) ? (CB+1)'(ay) - (CB+1)'(by) : (CB+1)'(by) - (CB+1)'(ay);
        nl = (ax < bx) ? ax : bx;
        nb = (ay < by) ? ay : by;
        too_small = (32'(w) < 32'(min_side_reg)) || (32'(h) < 32'(min_side_reg));
        full = 32'(count_reg) >= MAX_RECTS;
        do_add = accept && cmd == CMD_ADD && !(oppx && oppy) && !too_small && !full;
        do_del = accept && cmd == CMD_DELETE && sel_valid_reg &&
                 32'(sel_index_reg) < 32'(count_reg);
    end

    // chain of cells
    cell_flags_t flags [MAX_RECTS];
    logic [4*CB-1:0] rect_q [MAX_RECTS+1];
    assign rect_q[MAX_RECTS] = '0;

    for (genvar i = 0; i < MAX_RECTS; i++)
    begin : g_cell
        rot_cell #(.CB(CB)) u_cell (
            .clk(clk),
            .load(do_add && 32'(count_reg) == i),
            .shift(do_del && i >= 32'(sel_index_reg)),
            .new_l(nl), .new_b(nb), .new_w(w[CB-1:0]), .new_h(h[CB-1:0]),
            .nbr_in(rect_q[i+1]),
            .rect_out(rect_q[i]),
            .occ(i < 32'(count_reg)),
            .ax(ax), .ay(ay), .bx(bx), .by(by),
            .flags(flags[i])
        );
    end

    // newest containing cell and oldest hit cell
    logic          any_c, any_h;
    logic [IW-1:0] c_idx, h_idx;
    always_comb
    begin
        any_c = 1'b0; c_idx = '0; any_h = 1'b0; h_idx = '0;
        for (int i = 0; i < MAX_RECTS; i++)
        begin
            if (flags[i].contains)
            begin
                any_c = 1'b1; c_idx = IW'(i);
            end
        end
        for (int i = MAX_RECTS - 1; i >= 0; i--)
        begin
            if (flags[i].hit)
            begin
                any_h = 1'b1; h_idx = IW'(i);
            end
        end
    end

    always_comb
    begin
        logic [2:0] st;
        logic hit_o;
        logic [IW-1:0] hi;
        st = ST_DONE; hit_o = 1'b0; hi = '0;
        count_next = count_reg;
        sel_valid_next = sel_valid_reg;
        sel_index_next = sel_index_reg;
        case (cmd)
            CMD_ADD:
            begin
                if (oppx && oppy) st = ST_OPPOSITE;
                else if (too_small) st = ST_SMALL;
                else if (full) st = ST_FULL;
                else count_next = count_reg + 1'b1;
            end
            CMD_DELETE:
            begin
                if (do_del) count_next = count_reg - 1'b1;
                else st = ST_NONE;
                sel_valid_next = 1'b0;
                sel_index_next = '0;
            end
            CMD_SELECT:
            begin
                sel_valid_next = any_c;
                sel_index_next = any_c ? c_idx : '0;
                st = any_c ? ST_DONE : ST_NONE;
            end
            default:
            begin
                hit_o = any_h;
                hi = h_idx;
            end
        endcase
        out_data_next = ODW'({count_next,
                              sel_valid_next ? sel_index_next : {IW{1'b0}},
                              sel_valid_next, hi, hit_o, st});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_side_reg  <= MIN_SIDE_RESET;
            count_reg     <= '0;
            sel_valid_reg <= 1'b0;
            sel_index_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid) min_side_reg <= cfg_data;
            if (accept)
            begin
                count_reg     <= count_next;
                sel_valid_reg <= sel_valid_next;
                sel_index_reg <= sel_index_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) out_data_reg <= out_data_next;
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MAX_RECTS) else $error("count overflow");
    a_sel_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        sel_valid_reg |-> 32'(sel_index_reg) < 32'(count_reg))
        else $error("selection beyond table");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat dropped");
`endif
endmodule
`default_nettype wire

### rtl/rot_cell.sv
// One table cell: holds a rectangle, shifts from its upper neighbor on delete,
// and tests point containment and segment edge hit. Uses rot_pkg.
`default_nettype none
module rot_cell import rot_pkg::*; #(
    parameter int CB = COORD_BITS_DEF
) (
    input  wire              clk,
    input  wire              load,
    input  wire              shift,
    input  wire [CB-1:0]     new_l,
    input  wire [CB-1:0]     new_b,
    input  wire [CB-1:0]     new_w,
    input  wire [CB-1:0]     new_h,
    input  wire [4*CB-1:0]   nbr_in,
    output logic [4*CB-1:0]  rect_out,
    input  wire              occ,
    input  wire signed [CB-1:0] ax,
    input  wire signed [CB-1:0] ay,
    input  wire signed [CB-1:0] bx,
    input  wire signed [CB-1:0] by,
    output cell_flags_t      flags
);
    localparam int E = CB + 2;
    localparam int P = 2 * E + 2;
    logic [4*CB-1:0] rect_reg;
    logic signed [E-1:0] x1, y1, x2, y2, pax, pay, pbx, pby;

    always_ff @(posedge clk)
    begin
        if (load)
            rect_reg <= {new_h, new_w, new_b, new_l};
        else if (shift)
            rect_reg <= nbr_in;
    end
    assign rect_out = rect_reg;

    function automatic logic [1:0] orient(input logic signed [E-1:0] px, py, qx, qy,
                                          rx, ry);
        logic signed [P-1:0] v;
        v = P'(qy - py) * P'(rx - qx) - P'(qx - px) * P'(ry - qy);
        orient = (v == '0) ? 2'd0 : (v > 0 ? 2'd1 : 2'd2);
    endfunction

    function automatic logic in_box(input logic signed [E-1:0] px, py, qx, qy,
                                    rx, ry);
        in_box = ((qx >= px && qx <= rx) || (qx >= rx && qx <= px)) &&
                 ((qy >= py && qy <= ry) || (qy >= ry && qy <= py));
    endfunction

    function automatic logic seg_cross(input logic signed [E-1:0] cx, cy, dx, dy);
        logic [1:0] o1, o2, o3, o4;
        o1 = orient(pax, pay, pbx, pby, cx, cy);
        o2 = orient(pax, pay, pbx, pby, dx, dy);
        o3 = orient(cx, cy, dx, dy, pax, pay);
        o4 = orient(cx, cy, dx, dy, pbx, pby);
        seg_cross = (o1 != o2 && o3 != o4) ||
                    (o1 == 2'd0 && in_box(pax, pay, cx, cy, pbx, pby)) ||
                    (o2 == 2'd0 && in_box(pax, pay, dx, dy, pbx, pby)) ||
                    (o3 == 2'd0 && in_box(cx, cy, pax, pay, dx, dy)) ||
                    (o4 == 2'd0 && in_box(cx, cy, pbx, pby, dx, dy));
    endfunction

    always_comb
    begin
        x1  = E'($signed(rect_reg[CB-1:0]));
        y1  = E'($signed(rect_reg[2*CB-1:CB]));
        x2  = x1 + E'({1'b0, rect_reg[3*CB-1:2*CB]});
        y2  = y1 + E'({1'b0, rect_reg[4*CB-1:3*CB]});
        pax = E'(ax);
        pay = E'(ay);
        pbx = E'(bx);
        pby = E'(by);
        flags.contains = occ && x1 <= pax && pax <= x2 && y1 <= pay && pay <= y2;
        flags.hit = occ && (seg_cross(x1, y1, x2, y1) || seg_cross(x1, y1, x1, y2) ||
                            seg_cross(x2, y1, x2, y2) || seg_cross(x1, y2, x2, y2));
    end
endmodule
`default_nettype wire

### tb/tb_rect_obstacle_table_hit_test.sv
// Testbench for the rectangle obstacle table: directed and random commands,
// with a local table model predicting every result beat. Uses rot_pkg.
`default_nettype none
module tb_rect_obstacle_table_hit_test;
    import rot_pkg::*;

    localparam int NRECT = 16;

    typedef struct packed {
        logic [4:0] entry_count;
        logic [3:0] sel_index;
        logic       sel_valid;
        logic [3:0] hit_index;
        logic       hit;
        logic [2:0] status;
    } table_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    rect_obstacle_table_hit_test dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Shadow table
    longint       obs_left [NRECT];
    longint       obs_bottom [NRECT];
    longint       obs_w [NRECT];
    longint       obs_h [NRECT];
    int           obs_count = 0;
    bit           obs_sel_valid = 0;
    int           obs_sel_index = 0;
    longint       obs_min_side = MIN_SIDE_RESET;

    table_reply_t replies_due [$];
    int           fail_count = 0;
    bit           hold_off = 0;   // long receiver stall when set

    function automatic int orient3(longint px, longint py, longint qx, longint qy,
                                   longint rx, longint ry);
        longint v;
        v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
        return (v == 0) ? 0 : ((v > 0) ? 1 : 2);
    endfunction

    function automatic bit on_box(longint px, longint py, longint qx, longint qy,
                                  longint rx, longint ry);
        longint xl, xh, yl, yh;
        xl = (px < rx) ? px : rx;
        xh = (px < rx) ? rx : px;
        yl = (py < ry) ? py : ry;
        yh = (py < ry) ? ry : py;
        return qx >= xl && qx <= xh && qy >= yl && qy <= yh;
    endfunction

    function automatic bit segs_touch(longint ax, longint ay, longint bx, longint by,
                                      longint cx, longint cy, longint dx, longint dy);
        int o1, o2, o3, o4;
        o1 = orient3(ax, ay, bx, by, cx, cy);
        o2 = orient3(ax, ay, bx, by, dx, dy);
        o3 = orient3(cx, cy, dx, dy, ax, ay);
        o4 = orient3(cx, cy, dx, dy, bx, by);
        if (o1 != o2 && o3 != o4) return 1;
        if (o1 == 0 && on_box(ax, ay, cx, cy, bx, by)) return 1;
        if (o2 == 0 && on_box(ax, ay, dx, dy, bx, by)) return 1;
        if (o3 == 0 && on_box(cx, cy, ax, ay, dx, dy)) return 1;
        if (o4 == 0 && on_box(cx, cy, bx, by, dx, dy)) return 1;
        return 0;
    endfunction

    // Advance the shadow table by one command and return the reply it produces
    function automatic table_reply_t apply_command(logic [1:0] cmd,
            logic signed [15:0] ax16, logic signed [15:0] ay16,
            logic signed [15:0] bx16, logic signed [15:0] by16);
        table_reply_t r;
        longint ax, ay, bx, by, w, h, x1, y1, x2, y2;
        bit oppx, oppy;
        ax = ax16; ay = ay16; bx = bx16; by = by16;
        r = '0;
        case (cmd)
            CMD_ADD: begin
                oppx = (ax < 0 && bx > 0) || (ax > 0 && bx < 0);
                oppy = (ay < 0 && by > 0) || (ay > 0 && by < 0);
                w = (ax > bx) ? ax - bx : bx - ax;
                h = (ay > by) ? ay - by : by - ay;
                if (oppx && oppy) r.status = ST_OPPOSITE;
                else if (w < obs_min_side || h < obs_min_side) r.status = ST_SMALL;
                else if (obs_count >= NRECT) r.status = ST_FULL;
                else
                begin
                    obs_left[obs_count] = (ax < bx) ? ax : bx;
                    obs_bottom[obs_count] = (ay < by) ? ay : by;
                    obs_w[obs_count] = w;
                    obs_h[obs_count] = h;
                    obs_count++;
                    r.status = ST_DONE;
                end
            end
            CMD_DELETE: begin
                if (!obs_sel_valid || obs_sel_index >= obs_count) r.status = ST_NONE;
                else
                begin
                    for (int i = obs_sel_index; i + 1 < obs_count; i++)
                    begin
                        obs_left[i] = obs_left[i+1];
                        obs_bottom[i] = obs_bottom[i+1];
                        obs_w[i] = obs_w[i+1];
                        obs_h[i] = obs_h[i+1];
                    end
                    obs_count--;
                    r.status = ST_DONE;
                end
                obs_sel_valid = 0;
                obs_sel_index = 0;
            end
            CMD_SELECT: begin
                obs_sel_valid = 0;
                obs_sel_index = 0;
                r.status = ST_NONE;
                for (int i = obs_count - 1; i >= 0; i--)
                begin
                    x1 = obs_left[i]; y1 = obs_bottom[i];
                    x2 = x1 + obs_w[i]; y2 = y1 + obs_h[i];
                    if (x1 <= ax && ax <= x2 && y1 <= ay && ay <= y2)
                    begin
                        obs_sel_valid = 1;
                        obs_sel_index = i;
                        r.status = ST_DONE;
                        break;
                    end
                end
            end
            default: begin
                r.status = ST_DONE;
                for (int i = 0; i < obs_count; i++)
                begin
                    x1 = obs_left[i]; y1 = obs_bottom[i];
                    x2 = x1 + obs_w[i]; y2 = y1 + obs_h[i];
                    if (segs_touch(ax, ay, bx, by, x1, y1, x2, y1) ||
                        segs_touch(ax, ay, bx, by, x1, y1, x1, y2) ||
                        segs_touch(ax, ay, bx, by, x2, y1, x2, y2) ||
                        segs_touch(ax, ay, bx, by, x1, y2, x2, y2))
                    begin
                        r.hit = 1;
                        r.hit_index = i[3:0];
                        break;
                    end
                end
            end
        endcase
        r.sel_valid = obs_sel_valid;
        r.sel_index = obs_sel_valid ? obs_sel_index[3:0] : 4'd0;
        r.entry_count = obs_count[4:0];
        return r;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one command beat; drive at the falling edge, accept at the rising edge.
    // Valid stays high on return so the next beat can follow without valid dropping.
    task automatic send_command(logic [1:0] cmd, logic [15:0] ax, logic [15:0] ay,
                                logic [15:0] bx, logic [15:0] by, bit with_gap = 1);
        int gap;
        gap = with_gap ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= {6'd0, by, bx, ay, ax, cmd};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        replies_due = {replies_due, apply_command(cmd, ax, ay, bx, by)};
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write min_side while idle
    task automatic write_min_side(logic [15:0] v);
        wait_drained();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        obs_min_side = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random readiness, with an optional long stall
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off) m_axis_tready <= 1'b0;
            else m_axis_tready <= (pick_gap() == 0);
        end
    end

    // Checker of result beats
    always @(posedge clk)
    begin
        table_reply_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[17:0];
            if (replies_due.size() == 0)
            begin
                $error("unexpected result beat %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = replies_due.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.hit !== want.hit)
                begin
                    $error("hit expected %0d actual %0d", want.hit, got.hit);
                    fail_count++;
                end
                if (got.hit_index !== want.hit_index)
                begin
                    $error("hit_index expected %0d actual %0d", want.hit_index,
                           got.hit_index);
                    fail_count++;
                end
                if (got.sel_valid !== want.sel_valid)
                begin
                    $error("sel_valid expected %0d actual %0d", want.sel_valid,
                           got.sel_valid);
                    fail_count++;
                end
                if (got.sel_index !== want.sel_index)
                begin
                    $error("sel_index expected %0d actual %0d", want.sel_index,
                           got.sel_index);
                    fail_count++;
                end
                if (got.entry_count !== want.entry_count)
                begin
                    $error("entry_count expected %0d actual %0d", want.entry_count,
                           got.entry_count);
                    fail_count++;
                end
            end
        end
    end

    // Random coordinate: mostly a small window so shapes overlap, some full range
    function automatic logic [15:0] rand_coord();
        int p;
        p = $urandom_range(0, 9);
        if (p < 7) return 16'($signed($urandom_range(0, 400)) - 200);
        if (p < 8) return ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
        return 16'($urandom);
    endfunction

    // Directed: field extremes, every command and every rejection path
    task automatic test_directed();
        send_command(CMD_DELETE, 0, 0, 0, 0);               // nothing selected
        send_command(CMD_SELECT, 0, 0, 0, 0);               // empty table
        send_command(CMD_CHECK, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        send_command(CMD_ADD, -16'sd5, -16'sd5, 16'sd50, 16'sd50);     // opposite quadrants
        send_command(CMD_ADD, 0, -16'sd30, 16'sd40, 16'sd30);          // zero not opposite
        send_command(CMD_ADD, 16'sd10, 16'sd10, 16'sd15, 16'sd100);    // too small
        send_command(CMD_ADD, 16'sd100, 16'sd100, 16'sd10, 16'sd10);   // swapped corners
        send_command(CMD_ADD, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff); // opposite
        send_command(CMD_ADD, 16'h8000, 16'h8000, 16'hfff0, 16'hfff0); // huge, negative
        send_command(CMD_ADD, 16'h0000, 16'h0000, 16'h7fff, 16'h7fff);
        send_command(CMD_SELECT, 16'sd10, 16'sd10, 0, 0);   // edge inclusive
        send_command(CMD_SELECT, 16'sd50, 16'sd50, 0, 0);   // newest containing
        send_command(CMD_CHECK, 16'sd30, 16'sd30, 16'sd60, 16'sd60); // wholly inside
        send_command(CMD_CHECK, 16'sd0, 16'sd10, 16'sd200, 16'sd10); // collinear edge
        send_command(CMD_CHECK, 16'sd5, 16'sd5, 16'sd10, 16'sd10);   // touches corner
        send_command(CMD_CHECK, -16'sd1, 16'h7fff, 16'h7fff, -16'sd1);
        send_command(CMD_DELETE, 0, 0, 0, 0);
        send_command(CMD_SELECT, 16'h7fff, 16'h7fff, 0, 0);
        send_command(CMD_DELETE, 0, 0, 0, 0);
        for (int i = 0; i < 17; i++)                        // fill, then full
            send_command(CMD_ADD, 16'(i * 20), 0, 16'(i * 20 + 15), 16'sd15);
        send_command(CMD_CHECK, 16'sd7, -16'sd50, 16'sd7, 16'sd50);
    endtask

    task automatic test_random(int n);
        logic [1:0] cmd;
        int p;
        for (int k = 0; k < n; k++)
        begin
            p = $urandom_range(0, 99);
            cmd = (p < 30) ? CMD_ADD : (p < 45) ? CMD_DELETE : (p < 70) ? CMD_SELECT
                : CMD_CHECK;
            // Select right before a delete so deletes actually remove entries
            if (cmd == CMD_DELETE && $urandom_range(0, 3) != 0 && obs_count > 0)
                send_command(CMD_SELECT, 16'(obs_left[0] + 1), 16'(obs_bottom[0] + 1), 0, 0);
            send_command(cmd, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    // Receiver stalls for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1;
                repeat (60) @(negedge clk);
                hold_off = 0;
            end
            for (int k = 0; k < 20; k++)
                send_command(CMD_CHECK, rand_coord(), rand_coord(), rand_coord(),
                             rand_coord(), 0);
        join
        wait_drained();   // sender pauses until all results are in
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        write_min_side(16'd0);
        test_random(450);
        write_min_side(16'hffff);
        test_random(150);
        write_min_side(16'd1);
        test_backpressure();
        test_random(550);
        write_min_side(16'd40);
        test_random(550);
        wait_drained();
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("rect_obstacle_table_hit_test test passed");
        else
            $display("rect_obstacle_table_hit_test test failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("rect_obstacle_table_hit_test test failed");
        $finish;
    end
endmodule
`default_nettype wire
